// ===== rtl/sli_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sli_pkg
// Shared types and constants of the sorted list store.
// ----------------------------------------------------------------------------
package sli_pkg;

    localparam int VALUE_W     = 32;
    localparam int POS_W       = 7;
    localparam int INDEX_W     = 6;
    localparam int COUNT_W     = 7;
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 48;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_READ   = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_BAD   = 2'd2,
        STATUS_EMPTY = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_ROTATE
    } cell_op_t;

    typedef enum logic {
        ST_IDLE,
        ST_READOUT
    } state_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        cell_op_t                   op;
        logic signed [VALUE_W-1:0]  value;    // value to insert
        logic        [INDEX_W-1:0]  del_idx;  // 0-based entry to remove
        logic        [COUNT_W-1:0]  count;    // entries held before this op
    } cell_ctrl_t;

endpackage

// ===== rtl/sli_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sli_cell
// One slot of the sorted chain: holds one entry, shifts with its neighbors.
// ----------------------------------------------------------------------------
module sli_cell #(
    parameter int INDEX = 0
) (
    input  logic                               clk,
    input  sli_pkg::cell_ctrl_t                ctrl,
    input  logic                               prev_lt,
    input  logic signed [sli_pkg::VALUE_W-1:0] prev_value,
    input  logic signed [sli_pkg::VALUE_W-1:0] next_value,
    input  logic signed [sli_pkg::VALUE_W-1:0] head_value,
    output logic                               lt,
    output logic signed [sli_pkg::VALUE_W-1:0] value
);

    localparam logic [sli_pkg::COUNT_W-1:0] IDX = sli_pkg::COUNT_W'(INDEX);

    logic signed [sli_pkg::VALUE_W-1:0] value_reg;
    logic signed [sli_pkg::VALUE_W-1:0] value_next;
    logic                               valid;

    assign valid = IDX < ctrl.count;
    assign lt    = valid && (value_reg < ctrl.value);
    assign value = value_reg;

    always_comb
    begin
        value_next = value_reg;
        case (ctrl.op)
            sli_pkg::CELL_INSERT:
            begin
                // first slot not below the new value takes it, later ones shift up
                if (!lt)
                begin
                    value_next = prev_lt ? ctrl.value : prev_value;
                end
            end
            sli_pkg::CELL_DELETE:
            begin
                if (IDX >= sli_pkg::COUNT_W'(ctrl.del_idx))
                begin
                    value_next = next_value;
                end
            end
            sli_pkg::CELL_ROTATE:
            begin
                // ring over the occupied slots; tail takes the head
                value_next = (IDX == ctrl.count - sli_pkg::COUNT_W'(1)) ? head_value
                                                                       : next_value;
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

// ===== rtl/sorted_list_insert_delete.sv =====
`timescale 1ns / 1ps
// Results: the result word of an insert, delete, unused command or read of an empty
//   store is loaded into the output register on the edge that takes the item; a read-out
//   enters the read-out state on acceptance, then emits one word per cycle while the sink is ready.
// Occupancy: insert and delete each make a single shift of the cell chain; a read-out
//   of n entries holds off new input through its acceptance and its n rotations.
// Reset: entry count and output valid clear at once; cell contents are not cleared.
// ----------------------------------------------------------------------------
// sorted_list_insert_delete
// Ascending store of signed 32-bit entries built as a chain of shift cells.
// ----------------------------------------------------------------------------
module sorted_list_insert_delete #(
    parameter int CAPACITY = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [31:0] item_value, [38:32] position, [39] zero
    input  logic [sli_pkg::IN_TDATA_W-1:0]     s_tdata,
    // [1:0] cmd
    input  logic [sli_pkg::CMD_W-1:0]          s_tuser,
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [1:0] status, [33:2] out_value, [39:34] out_index,
    // [46:40] entry_count, [47] zero
    output logic [sli_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic                               m_tlast
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);

    // ------------------------------------------------------------------
    // input word fields
    // ------------------------------------------------------------------
    sli_pkg::cmd_t                       in_cmd;
    logic signed [sli_pkg::VALUE_W-1:0]  in_value;
    logic        [sli_pkg::POS_W-1:0]    in_pos;

    assign in_cmd   = sli_pkg::cmd_t'(s_tuser);
    assign in_value = s_tdata[sli_pkg::VALUE_W-1:0];
    assign in_pos   = s_tdata[sli_pkg::VALUE_W +: sli_pkg::POS_W];

    // ------------------------------------------------------------------
    // control state
    // ------------------------------------------------------------------
    sli_pkg::state_t     state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;

    // output register (payload has no reset)
    logic                                 out_valid_reg;
    sli_pkg::status_t                     out_status_reg, out_status_next;
    logic signed [sli_pkg::VALUE_W-1:0]   out_value_reg, out_value_next;
    logic [sli_pkg::INDEX_W-1:0]          out_index_reg, out_index_next;
    logic [sli_pkg::COUNT_W-1:0]          out_count_reg, out_count_next;
    logic                                 out_last_reg, out_last_next;
    logic                                 out_load;

    logic                out_free;
    logic                in_acc;
    logic                is_full;
    logic                is_empty;
    logic                pos_bad;
    logic                ro_last;

    sli_pkg::cell_ctrl_t ctrl;

    // chain wiring
    logic                               lt_w  [CAPACITY];
    logic signed [sli_pkg::VALUE_W-1:0] val_w [CAPACITY];

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == sli_pkg::ST_IDLE) && out_free;
    assign in_acc   = s_tvalid && s_tready;

    assign is_full  = count_reg == CNT_W'(CAPACITY);
    assign is_empty = count_reg == '0;
    assign pos_bad  = (in_pos == '0) || (in_pos > sli_pkg::POS_W'(count_reg));
    assign ro_last  = idx_reg == IDX_W'(count_reg - CNT_W'(1));

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sli_pkg::ST_IDLE:
            begin
                if (in_acc && in_cmd == sli_pkg::CMD_READ && !is_empty)
                begin
                    state_next = sli_pkg::ST_READOUT;
                end
            end
            sli_pkg::ST_READOUT:
            begin
                if (out_free && ro_last)
                begin
                    state_next = sli_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sli_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // outputs: chain command, count update, result word
    // ------------------------------------------------------------------
    always_comb
    begin
        ctrl.op         = sli_pkg::CELL_HOLD;
        ctrl.value      = in_value;
        ctrl.del_idx    = sli_pkg::INDEX_W'(in_pos - sli_pkg::POS_W'(1));
        ctrl.count      = sli_pkg::COUNT_W'(count_reg);
        count_next      = count_reg;
        idx_next        = idx_reg;
        out_load        = 1'b0;
        out_status_next = sli_pkg::STATUS_OK;
        out_value_next  = '0;
        out_index_next  = '0;
        out_count_next  = sli_pkg::COUNT_W'(count_reg);
        out_last_next   = 1'b1;
        case (state_reg)
            sli_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    case (in_cmd)
                        sli_pkg::CMD_INSERT:
                        begin
                            out_load = 1'b1;
                            if (is_full)
                            begin
                                out_status_next = sli_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                ctrl.op        = sli_pkg::CELL_INSERT;
                                count_next     = count_reg + CNT_W'(1);
                                out_count_next = sli_pkg::COUNT_W'(count_reg + CNT_W'(1));
                            end
                        end
                        sli_pkg::CMD_DELETE:
                        begin
                            out_load = 1'b1;
                            if (is_empty)
                            begin
                                out_status_next = sli_pkg::STATUS_EMPTY;
                            end
                            else if (pos_bad)
                            begin
                                out_status_next = sli_pkg::STATUS_BAD;
                            end
                            else
                            begin
                                ctrl.op        = sli_pkg::CELL_DELETE;
                                count_next     = count_reg - CNT_W'(1);
                                out_count_next = sli_pkg::COUNT_W'(count_reg - CNT_W'(1));
                            end
                        end
                        sli_pkg::CMD_READ:
                        begin
                            if (is_empty)
                            begin
                                out_load        = 1'b1;
                                out_status_next = sli_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                idx_next = '0;
                            end
                        end
                        default:
                        begin
                            // unused code: plain acknowledge
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            sli_pkg::ST_READOUT:
            begin
                if (out_free)
                begin
                    // head of the ring is the next entry in order
                    out_load       = 1'b1;
                    ctrl.op        = sli_pkg::CELL_ROTATE;
                    out_value_next = val_w[0];
                    out_index_next = sli_pkg::INDEX_W'(idx_reg);
                    out_last_next  = ro_last;
                    idx_next       = idx_reg + IDX_W'(1);
                end
            end
            default:
            begin
                ctrl.op = sli_pkg::CELL_HOLD;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sli_pkg::ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_status_reg <= out_status_next;
            out_value_reg  <= out_value_next;
            out_index_reg  <= out_index_next;
            out_count_reg  <= out_count_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {1'b0, out_count_reg, out_index_reg, out_value_reg, out_status_reg};

    // ------------------------------------------------------------------
    // cell chain: cell 0 holds the smallest entry
    // ------------------------------------------------------------------
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic                               prev_lt_w;
        logic signed [sli_pkg::VALUE_W-1:0] prev_val_w;
        logic signed [sli_pkg::VALUE_W-1:0] next_val_w;

        if (g == 0)
        begin : g_first
            assign prev_lt_w  = 1'b1;
            assign prev_val_w = in_value;
        end
        else
        begin : g_mid
            assign prev_lt_w  = lt_w[g-1];
            assign prev_val_w = val_w[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign next_val_w = val_w[0];
        end
        else
        begin : g_inner
            assign next_val_w = val_w[g+1];
        end

        sli_cell #(
            .INDEX(g)
        ) u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .prev_lt   (prev_lt_w),
            .prev_value(prev_val_w),
            .next_value(next_val_w),
            .head_value(val_w[0]),
            .lt        (lt_w[g]),
            .value     (val_w[g])
        );
    end

endmodule

// ===== rtl/sli_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sli_checker
// Port-level checks of the sorted list store, bound to the top level.
// ----------------------------------------------------------------------------
module sli_checker #(
    parameter int CAPACITY = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [sli_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                            m_tlast
);

    logic [sli_pkg::STATUS_W-1:0] st;
    logic [sli_pkg::COUNT_W-1:0]  cnt;
    logic [sli_pkg::VALUE_W-1:0]  val;

    assign st  = m_tdata[sli_pkg::STATUS_W-1:0];
    assign val = m_tdata[sli_pkg::STATUS_W +: sli_pkg::VALUE_W];
    assign cnt = m_tdata[40 +: sli_pkg::COUNT_W];

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result word changed while stalled");

    a_no_accept_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |-> !(m_tvalid && !m_tready))
        else $error("input taken while result register blocked");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> cnt <= sli_pkg::COUNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && st == sli_pkg::STATUS_FULL |-> cnt == sli_pkg::COUNT_W'(CAPACITY))
        else $error("full status with store not full");

    a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (st == sli_pkg::STATUS_EMPTY || !m_tlast)
            |-> (st == sli_pkg::STATUS_EMPTY) == (cnt == '0) && (m_tlast || val == val))
        else $error("empty status inconsistent with entry count");

endmodule

bind sorted_list_insert_delete sli_checker #(
    .CAPACITY(CAPACITY)
) u_sli_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sorted list store. A shadow copy of the store
// predicts every result word of each accepted command word. Both stream
// sides get random idle bursts. The run covers empty and full stores, bad
// delete positions, duplicates and the extreme signed values.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CAPACITY     = 16;
    localparam int MAX_CYCLES   = 400000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_WORDS = 200;
    localparam int QUIET_WORDS  = 40;

    // command code with no function; the block answers it without a change
    localparam logic [sli_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam logic signed [sli_pkg::VALUE_W-1:0] VAL_MIN = 32'h8000_0000;
    localparam logic signed [sli_pkg::VALUE_W-1:0] VAL_MAX = 32'h7FFF_FFFF;

    // traffic mix of one random phase
    localparam int MIX_GROW   = 0;
    localparam int MIX_SHRINK = 1;
    localparam int MIX_BLEND  = 2;

    typedef struct packed {
        sli_pkg::status_t                   status;
        logic signed [sli_pkg::VALUE_W-1:0] value;
        logic        [sli_pkg::INDEX_W-1:0] index;
        logic        [sli_pkg::COUNT_W-1:0] count;
        logic                               last;
    } result_t;

    // ------------------------------------------------------------------------
    // Shadow store plus queue of result words still owed by the block
    // ------------------------------------------------------------------------
    class sorted_list_checker;
        logic signed [sli_pkg::VALUE_W-1:0] shadow_entries [CAPACITY];
        int unsigned                        held   = 0;
        int unsigned                        errors = 0;
        result_t                            owed_words [$];

        function void owe(sli_pkg::status_t st, logic signed [sli_pkg::VALUE_W-1:0] v,
                          int unsigned idx, int unsigned cnt, bit lst);
            result_t r;
            r.status = st;
            r.value  = v;
            r.index  = sli_pkg::INDEX_W'(idx);
            r.count  = sli_pkg::COUNT_W'(cnt);
            r.last   = lst;
            owed_words.push_back(r);
        endfunction

        function int unsigned pending();
            return owed_words.size();
        endfunction

        // apply one accepted command word to the shadow store
        function void take_command(logic [sli_pkg::CMD_W-1:0] cmd,
                                   logic signed [sli_pkg::VALUE_W-1:0] v,
                                   logic [sli_pkg::POS_W-1:0] pos);
            int unsigned at;
            int          i;
            case (cmd)
                sli_pkg::CMD_INSERT:
                begin
                    if (held >= CAPACITY)
                    begin
                        owe(sli_pkg::STATUS_FULL, '0, 0, held, 1'b1);
                    end
                    else
                    begin
                        // equal values go ahead of those already stored
                        at = 0;
                        while (at < held && shadow_entries[at] < v)
                            at++;
                        for (i = held; i > at; i--)
                            shadow_entries[i] = shadow_entries[i-1];
                        shadow_entries[at] = v;
                        held++;
                        owe(sli_pkg::STATUS_OK, '0, 0, held, 1'b1);
                    end
                end
                sli_pkg::CMD_DELETE:
                begin
                    if (held == 0)
                    begin
                        owe(sli_pkg::STATUS_EMPTY, '0, 0, 0, 1'b1);
                    end
                    else if (pos < 1 || pos > held)
                    begin
                        owe(sli_pkg::STATUS_BAD, '0, 0, held, 1'b1);
                    end
                    else
                    begin
                        for (i = pos - 1; i + 1 < held; i++)
                            shadow_entries[i] = shadow_entries[i+1];
                        held--;
                        owe(sli_pkg::STATUS_OK, '0, 0, held, 1'b1);
                    end
                end
                sli_pkg::CMD_READ:
                begin
                    if (held == 0)
                        owe(sli_pkg::STATUS_EMPTY, '0, 0, 0, 1'b1);
                    else
                        for (i = 0; i < held; i++)
                            owe(sli_pkg::STATUS_OK, shadow_entries[i], i, held,
                                i + 1 == held);
                end
                default:
                begin
                    owe(sli_pkg::STATUS_OK, '0, 0, held, 1'b1);
                end
            endcase
        endfunction

        task report(string msg);
            errors++;
            $display("ERROR: %s", msg);
        endtask

        task check_word(logic [sli_pkg::OUT_TDATA_W-1:0] tdata, logic tlast);
            result_t got;
            result_t want;
            got.status = sli_pkg::status_t'(tdata[1:0]);
            got.value  = tdata[33:2];
            got.index  = tdata[39:34];
            got.count  = tdata[46:40];
            got.last   = tlast;
            if (owed_words.size() == 0)
            begin
                report($sformatf("unexpected result word %h last %b", tdata, tlast));
                return;
            end
            want = owed_words.pop_front();
            if (got.status !== want.status)
                report($sformatf("status got %0d want %0d", got.status, want.status));
            if (got.value !== want.value)
                report($sformatf("value got %h want %h", got.value, want.value));
            if (got.index !== want.index)
                report($sformatf("index got %0d want %0d", got.index, want.index));
            if (got.count !== want.count)
                report($sformatf("count got %0d want %0d", got.count, want.count));
            if (got.last !== want.last)
                report($sformatf("last got %b want %b", got.last, want.last));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic                            clk      = 1'b0;
    logic                            rst_n    = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [sli_pkg::IN_TDATA_W-1:0]  s_tdata  = '0;   // [31:0] value, [38:32] position
    logic [sli_pkg::CMD_W-1:0]       s_tuser  = '0;   // [1:0] cmd
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [sli_pkg::OUT_TDATA_W-1:0] m_tdata;         // status, value, index, count
    logic                            m_tlast;

    bit          src_gaps    = 1'b1;   // sender may insert idle bursts
    bit          sink_stalls = 1'b1;   // receiver may drop tready in bursts
    int unsigned cycle_count = 0;
    int unsigned words_sent  = 0;

    sorted_list_checker sb = new;

    sorted_list_insert_delete #(
        .CAPACITY (CAPACITY)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // watchdog: a hung handshake ends the run here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYCLES)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Result side: check each accepted word, then pick tready for next cycle
    // ------------------------------------------------------------------------
    initial
    begin : sink
        int unsigned stall;
        stall = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_word(m_tdata, m_tlast);
            if (stall == 0 && sink_stalls && $urandom_range(0, 5) == 0)
                stall = $urandom_range(1, 11);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                stall--;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------------

    // Offer one command word and hold it until taken. tvalid stays high
    // between back-to-back words; an idle burst lowers it first.
    task automatic send_word(input logic [sli_pkg::CMD_W-1:0] cmd,
                             input logic signed [sli_pkg::VALUE_W-1:0] v,
                             input logic [sli_pkg::POS_W-1:0] pos);
        int unsigned gap;
        if (src_gaps && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 11);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {1'b0, pos, v};
        do
            @(posedge clk);
        while (!s_tready);
        sb.take_command(cmd, v, pos);
        if (cmd != CMD_UNUSED)
            words_sent++;
    endtask

    // stop offering words until every owed result word is back
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic random_word(input int mix);
        int unsigned                        roll;
        int unsigned                        pick;
        logic [sli_pkg::CMD_W-1:0]          cmd;
        logic signed [sli_pkg::VALUE_W-1:0] v;
        logic [sli_pkg::POS_W-1:0]          pos;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_GROW:
                cmd = roll < 70 ? sli_pkg::CMD_INSERT : roll < 85 ? sli_pkg::CMD_DELETE :
                      roll < 98 ? sli_pkg::CMD_READ : CMD_UNUSED;
            MIX_SHRINK:
                cmd = roll < 20 ? sli_pkg::CMD_INSERT : roll < 85 ? sli_pkg::CMD_DELETE :
                      roll < 98 ? sli_pkg::CMD_READ : CMD_UNUSED;
            default:
                cmd = roll < 40 ? sli_pkg::CMD_INSERT : roll < 75 ? sli_pkg::CMD_DELETE :
                      roll < 97 ? sli_pkg::CMD_READ : CMD_UNUSED;
        endcase

        // values: duplicates of stored entries, extremes, small, full range
        pick = $urandom_range(0, 7);
        if (pick < 2 && sb.held > 0)
            v = sb.shadow_entries[$urandom_range(0, sb.held - 1)];
        else if (pick == 2)
            case ($urandom_range(0, 3))
                0:       v = VAL_MIN;
                1:       v = VAL_MAX;
                2:       v = '0;
                default: v = -1;
            endcase
        else if (pick == 3)
            v = $signed($urandom_range(0, 15)) - 8;
        else
            v = $urandom;

        // positions: mostly in range, the rest just outside or far off
        pick = $urandom_range(0, 9);
        if (pick < 7 && sb.held > 0)
            pos = sli_pkg::POS_W'($urandom_range(1, sb.held));
        else if (pick == 7)
            pos = '0;
        else if (pick == 8)
            pos = sli_pkg::POS_W'(sb.held + 1);
        else
            pos = ($urandom_range(0, 1) == 0) ? 7'd64
                                              : sli_pkg::POS_W'($urandom_range(0, 64));

        send_word(cmd, v, pos);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int mix;
        int len;
        bit busy;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty store, unused code, extremes, bad positions, full
        send_word(sli_pkg::CMD_READ, '0, '0);
        send_word(sli_pkg::CMD_DELETE, '0, 7'd1);
        send_word(CMD_UNUSED, 32'h1234_5678, 7'd3);
        send_word(sli_pkg::CMD_INSERT, VAL_MIN, '0);
        send_word(sli_pkg::CMD_INSERT, VAL_MAX, '0);
        send_word(sli_pkg::CMD_INSERT, VAL_MIN, '0);      // equal to the head
        send_word(sli_pkg::CMD_INSERT, '0, '0);
        send_word(sli_pkg::CMD_DELETE, '0, 7'd0);         // position zero
        send_word(sli_pkg::CMD_DELETE, '0, 7'd5);         // one past the end
        send_word(sli_pkg::CMD_DELETE, '0, 7'd64);
        send_word(sli_pkg::CMD_READ, '0, '0);
        while (sb.held < CAPACITY)
            send_word(sli_pkg::CMD_INSERT, $urandom, '0);
        send_word(sli_pkg::CMD_INSERT, -1, '0);           // store full
        send_word(sli_pkg::CMD_READ, '0, '0);
        send_word(sli_pkg::CMD_DELETE, '0, 7'(CAPACITY)); // tail
        send_word(sli_pkg::CMD_DELETE, '0, 7'd1);         // head

        hold_until_drained();

        // random phases; the closing stretch runs with no idling at all
        words_sent = 0;
        while (words_sent < RANDOM_WORDS)
        begin
            busy        = words_sent < RANDOM_WORDS - QUIET_WORDS;
            mix         = $urandom_range(MIX_GROW, MIX_BLEND);
            len         = $urandom_range(8, 24);
            src_gaps    = busy && $urandom_range(0, 3) != 0;
            sink_stalls = busy && $urandom_range(0, 3) != 0;
            repeat (len)
                random_word(mix);
        end

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
